// ----- rtl/core/jeop_pkg.sv -----
// Shared constants and helpers for the JPEG Exif orientation reader.
// No dependencies; used by the channel interfaces and the top level.
package jeop_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ORIENT_W = 4;

  // Marker codes.
  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_SOS    = 8'hDA;
  localparam logic [7:0] MARK_EOI    = 8'hD9;
  localparam logic [7:0] MARK_APP1   = 8'hE1;

  // TIFF header and IFD entry constants.
  localparam logic [15:0] BO_INTEL    = 16'h4949;
  localparam logic [15:0] BO_MOTOROLA = 16'h4D4D;
  localparam logic [15:0] TIFF_MAGIC  = 16'd42;
  localparam logic [15:0] ORIENT_TAG  = 16'h0112;
  localparam logic [15:0] TYPE_SHORT  = 16'd3;
  localparam logic [3:0]  ENTRY_LAST  = 4'd11;  // index of the twelfth entry byte

  localparam logic [ORIENT_W-1:0] ORIENT_DEFAULT = 4'd1;
  localparam logic [ORIENT_W-1:0] ORIENT_MAX     = 4'd8;

  // Bytes of the Exif identifier "Exif\0\0".
  function automatic logic [7:0] exif_id_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h45;
      3'd1:    r = 8'h78;
      3'd2:    r = 8'h69;
      3'd3:    r = 8'h66;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] get16(input logic [15:0] v, input logic le);
    return le ? {v[7:0], v[15:8]} : v;
  endfunction

  function automatic logic [31:0] get32(input logic [31:0] v, input logic le);
    return le ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
  endfunction

endpackage

// ----- rtl/core/jeop_if.sv -----
// Valid/ready channel interfaces for the JPEG Exif orientation reader.
// Depends on jeop_pkg for the payload widths.
interface jeop_in_if;
  logic                           valid;
  logic                           ready;
  logic [jeop_pkg::BYTE_W-1:0]    data_byte;
  logic                           last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jeop_out_if;
  logic                           valid;
  logic                           ready;
  logic [jeop_pkg::ORIENT_W-1:0]  orientation;
  logic                           tag_found;

  modport source (output valid, output orientation, output tag_found, input ready);
  modport sink   (input valid, input orientation, input tag_found, output ready);
endinterface

// ----- rtl/core/jpeg_exif_orientation_parser_top.sv -----
// Each result is registered: it shows on the output channel in the cycle after its byte.
// Throughput: one byte per cycle unless stalled; each accepted byte updates the parse state.
// The only stall comes from the single result register when it is full and not taken.
// Reset (rst_n low, synchronous) returns the parser to waiting for the first SOI byte and
// empties the result register.
// Depends on jeop_pkg and the channel interfaces in jeop_if.sv.
module jpeg_exif_orientation_parser_top (
  input  logic      clk,
  input  logic      rst_n,
  jeop_in_if.sink   in_ch,
  jeop_out_if.source out_ch
);

  // The parser walks the stream one byte at a time. Each phase below handles one kind of
  // byte: the SOI marker, a marker prefix and code, the two length bytes, skipped payload,
  // the Exif identifier, the TIFF header, the gap up to IFD0, the entry count, the twelve
  // bytes of each directory entry, the rest of a matching segment and bytes after a result.
  typedef enum logic [3:0] {
    PH_SOI0, PH_SOI1, PH_MARK_FF, PH_MARK_CODE, PH_LEN_HI, PH_LEN_LO, PH_SKIP,
    PH_EXIF_ID, PH_TIFF_HDR, PH_SEEK_IFD, PH_COUNT, PH_ENTRY, PH_ENTRY_SKIP,
    PH_WAIT, PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] seg_rem_r, seg_rem_nxt;
  logic [15:0] tiff_size_r, tiff_size_nxt;
  logic [15:0] tiff_pos_r, tiff_pos_nxt;
  logic        le_r, le_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [15:0] ifd_off_r, ifd_off_nxt;
  logic [15:0] entries_r, entries_nxt;
  logic [3:0]  ebi_r, ebi_nxt;
  logic [3:0]  pending_r, pending_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [jeop_pkg::ORIENT_W-1:0] out_orient_r, out_orient_nxt;
  logic                          out_found_r, out_found_nxt;

  // Per-byte working values.
  logic        accept;
  logic [7:0]  b;
  logic [15:0] seg_dec;
  logic [31:0] shift_in;
  logic [15:0] seglen;
  logic [15:0] seg_after_len;
  logic [31:0] ifd32;
  logic [15:0] pos_inc;
  logic [15:0] cnt;
  logic [19:0] need;
  logic [15:0] avail;
  logic [15:0] val16;
  logic [3:0]  ebi_inc;
  logic        fin;
  logic [jeop_pkg::ORIENT_W-1:0] fin_orient;
  logic        fin_found;

  // The result register parts the two sides: a new byte is taken whenever the register
  // is empty or its request is being taken in this cycle.
  assign in_ch.ready        = !out_valid_r || out_ch.ready;
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.orientation = out_orient_r;
  assign out_ch.tag_found   = out_found_r;

  assign b        = in_ch.data_byte;
  // Payload bytes count down the segment, saturating at zero.
  assign seg_dec  = seg_rem_r - {15'd0, (seg_rem_r != 16'd0)};
  assign shift_in = {shift_r[23:0], b};
  assign seglen   = {shift_r[7:0], b};
  assign seg_after_len = seglen - 16'd2;
  assign ifd32    = jeop_pkg::get32(shift_in, le_r);
  assign pos_inc  = tiff_pos_r + 16'd1;
  assign cnt      = jeop_pkg::get16(shift_in[15:0], le_r);
  // Bytes that IFD0 needs: the count field and twelve bytes per entry.
  assign need     = 20'd2 + {1'b0, cnt, 3'b000} + {2'b00, cnt, 2'b00};
  assign avail    = tiff_size_r - ifd_off_r;
  assign val16    = jeop_pkg::get16(shift_in[15:0], le_r);
  assign ebi_inc  = ebi_r + 4'd1;

  always_comb begin
    phase_nxt     = phase_r;
    seg_rem_nxt   = seg_rem_r;
    tiff_size_nxt = tiff_size_r;
    tiff_pos_nxt  = tiff_pos_r;
    le_nxt        = le_r;
    shift_nxt     = shift_r;
    ifd_off_nxt   = ifd_off_r;
    entries_nxt   = entries_r;
    ebi_nxt       = ebi_r;
    pending_nxt   = pending_r;
    fin           = 1'b0;
    fin_orient    = jeop_pkg::ORIENT_DEFAULT;
    fin_found     = 1'b0;

    case (phase_r)
      PH_SOI0: begin
        if (b == jeop_pkg::MARK_PREFIX) phase_nxt = PH_SOI1;
        else fin = 1'b1;
      end
      PH_SOI1: begin
        if (b == jeop_pkg::MARK_SOI) phase_nxt = PH_MARK_FF;
        else fin = 1'b1;
      end
      PH_MARK_FF: begin
        if (b == jeop_pkg::MARK_PREFIX) phase_nxt = PH_MARK_CODE;
        else fin = 1'b1;
      end
      PH_MARK_CODE: begin
        // Start of scan or end of image before any Exif data means no tag.
        if (b == jeop_pkg::MARK_SOS || b == jeop_pkg::MARK_EOI) begin
          fin = 1'b1;
        end else begin
          shift_nxt = {24'd0, b};
          phase_nxt = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        shift_nxt = {16'd0, shift_r[7:0], b};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (seglen < 16'd2) begin
          fin = 1'b1;
        end else begin
          seg_rem_nxt = seg_after_len;
          if (shift_r[15:8] == jeop_pkg::MARK_APP1 && seg_after_len >= 16'd6) begin
            tiff_size_nxt = seg_after_len - 16'd6;
            ebi_nxt       = 4'd0;
            phase_nxt     = PH_EXIF_ID;
          end else begin
            phase_nxt = (seg_after_len == 16'd0) ? PH_MARK_FF : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        seg_rem_nxt = seg_dec;
        if (seg_dec == 16'd0) phase_nxt = PH_MARK_FF;
      end
      PH_EXIF_ID: begin
        seg_rem_nxt = seg_dec;
        // An APP1 that is not Exif is skipped as an ordinary segment.
        if (b != jeop_pkg::exif_id_byte(ebi_r[2:0])) begin
          phase_nxt = (seg_dec == 16'd0) ? PH_MARK_FF : PH_SKIP;
        end else begin
          ebi_nxt = ebi_inc;
          if (ebi_inc >= 4'd6) begin
            if (tiff_size_r < 16'd8) begin
              fin = 1'b1;
            end else begin
              tiff_pos_nxt = 16'd0;
              phase_nxt    = PH_TIFF_HDR;
            end
          end
        end
      end
      PH_TIFF_HDR: begin
        seg_rem_nxt = seg_dec;
        shift_nxt   = shift_in;
        if (tiff_pos_r == 16'd1) begin
          if (shift_in[15:0] == jeop_pkg::BO_INTEL) le_nxt = 1'b1;
          else if (shift_in[15:0] == jeop_pkg::BO_MOTOROLA) le_nxt = 1'b0;
          else fin = 1'b1;
        end else if (tiff_pos_r == 16'd3) begin
          if (jeop_pkg::get16(shift_in[15:0], le_r) != jeop_pkg::TIFF_MAGIC) fin = 1'b1;
        end else if (tiff_pos_r == 16'd7) begin
          // The offset must lie past the header and leave room for the count.
          if (ifd32 < 32'd8 || ifd32 >= {16'd0, tiff_size_r} ||
              ({16'd0, tiff_size_r} - ifd32) < 32'd2) begin
            fin = 1'b1;
          end
          ifd_off_nxt = ifd32[15:0];
        end
        if (!fin) begin
          tiff_pos_nxt = pos_inc;
          if (pos_inc >= 16'd8) begin
            ebi_nxt   = 4'd0;
            phase_nxt = (pos_inc == ifd32[15:0]) ? PH_COUNT : PH_SEEK_IFD;
          end
        end
      end
      PH_SEEK_IFD: begin
        seg_rem_nxt  = seg_dec;
        tiff_pos_nxt = pos_inc;
        if (pos_inc == ifd_off_r) begin
          ebi_nxt   = 4'd0;
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT: begin
        seg_rem_nxt = seg_dec;
        shift_nxt   = shift_in;
        ebi_nxt     = ebi_inc;
        if (ebi_inc >= 4'd2) begin
          entries_nxt = cnt;
          if ({4'd0, avail} < need || cnt == 16'd0) begin
            fin = 1'b1;
          end else begin
            ebi_nxt   = 4'd0;
            phase_nxt = PH_ENTRY;
          end
        end
      end
      PH_ENTRY, PH_ENTRY_SKIP: begin
        seg_rem_nxt = seg_dec;
        shift_nxt   = shift_in;
        if (phase_r == PH_ENTRY && ebi_r == 4'd9) begin
          // Value field of a matching entry: hold it until the segment ends.
          if (val16 < 16'd1 || val16 > {12'd0, jeop_pkg::ORIENT_MAX}) begin
            fin = 1'b1;
          end else begin
            pending_nxt = val16[3:0];
            phase_nxt   = PH_WAIT;
            if (seg_dec == 16'd0) begin
              fin        = 1'b1;
              fin_orient = val16[3:0];
              fin_found  = 1'b1;
            end
          end
        end else begin
          if (phase_r == PH_ENTRY && ebi_r == 4'd3) begin
            if (jeop_pkg::get16(shift_in[31:16], le_r) != jeop_pkg::ORIENT_TAG ||
                val16 != jeop_pkg::TYPE_SHORT) begin
              phase_nxt = PH_ENTRY_SKIP;
            end
          end else if (phase_r == PH_ENTRY && ebi_r == 4'd7) begin
            if (ifd32 != 32'd1) phase_nxt = PH_ENTRY_SKIP;
          end
          ebi_nxt = ebi_inc;
          if (ebi_r == jeop_pkg::ENTRY_LAST) begin
            ebi_nxt = 4'd0;
            if (entries_r <= 16'd1) begin
              entries_nxt = 16'd0;
              fin         = 1'b1;
            end else begin
              entries_nxt = entries_r - 16'd1;
              phase_nxt   = PH_ENTRY;
            end
          end
        end
      end
      PH_WAIT: begin
        seg_rem_nxt = seg_dec;
        if (seg_dec == 16'd0) begin
          fin        = 1'b1;
          fin_orient = pending_r;
          fin_found  = 1'b1;
        end
      end
      default: ;
    endcase

    if (fin) phase_nxt = PH_DONE;

    // The final byte of a stream always leaves exactly one request behind: the one this
    // byte produced, or a default result when none has been sent yet.
    if (in_ch.last_byte && !fin && phase_r != PH_DONE) begin
      fin        = 1'b1;
      fin_orient = jeop_pkg::ORIENT_DEFAULT;
      fin_found  = 1'b0;
    end

    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_orient_nxt = out_orient_r;
    out_found_nxt  = out_found_r;
    if (accept && fin) begin
      out_valid_nxt  = 1'b1;
      out_orient_nxt = fin_orient;
      out_found_nxt  = fin_found;
    end

    // After the final byte every stream starts afresh.
    if (in_ch.last_byte) begin
      phase_nxt     = PH_SOI0;
      seg_rem_nxt   = 16'd0;
      tiff_size_nxt = 16'd0;
      tiff_pos_nxt  = 16'd0;
      le_nxt        = 1'b0;
      shift_nxt     = 32'd0;
      ifd_off_nxt   = 16'd0;
      entries_nxt   = 16'd0;
      ebi_nxt       = 4'd0;
      pending_nxt   = jeop_pkg::ORIENT_DEFAULT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SOI0;
      seg_rem_r   <= 16'd0;
      tiff_size_r <= 16'd0;
      tiff_pos_r  <= 16'd0;
      le_r        <= 1'b0;
      shift_r     <= 32'd0;
      ifd_off_r   <= 16'd0;
      entries_r   <= 16'd0;
      ebi_r       <= 4'd0;
      pending_r   <= jeop_pkg::ORIENT_DEFAULT;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        seg_rem_r   <= seg_rem_nxt;
        tiff_size_r <= tiff_size_nxt;
        tiff_pos_r  <= tiff_pos_nxt;
        le_r        <= le_nxt;
        shift_r     <= shift_nxt;
        ifd_off_r   <= ifd_off_nxt;
        entries_r   <= entries_nxt;
        ebi_r       <= ebi_nxt;
        pending_r   <= pending_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    out_orient_r <= out_orient_nxt;
    out_found_r  <= out_found_nxt;
  end

  // A final byte always sends the parser back to the start of a stream.
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.last_byte |=> phase_r == PH_SOI0)
    else $error("parser did not restart after the final byte");

  // A found tag carries a legal orientation.
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |->
      out_orient_r >= 4'd1 && out_orient_r <= jeop_pkg::ORIENT_MAX)
    else $error("found orientation out of range");

  // Every failure reports the default orientation.
  a_fail_default: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_orient_r == jeop_pkg::ORIENT_DEFAULT)
    else $error("failure result without default orientation");

  // No byte is taken while a stalled request occupies the result register.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while result register is blocked");

  // Once a result has been produced the parser waits quietly for the final byte.
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_DONE && !in_ch.last_byte |=> phase_r == PH_DONE)
    else $error("parser left the finished phase before the final byte");

endmodule
